/* rtl/drc_pkg.sv */
// Package for the dirty region coalescer: shared widths, register indexes,
// reset values and the result record. No dependencies.
`timescale 1ns / 1ps

package drc_pkg;

  localparam int COORD_BITS_DEF = 8;   // default counter and span width
  localparam int CFG_W          = 9;   // width of a configuration register
  localparam int PIX_W          = 16;  // RGB565 pixel
  localparam int OUT_COORD_W    = 8;   // coordinate width on the result port

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 9'd135;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 9'd240;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } drc_cfg_idx_e;

  typedef struct packed {
    logic                   region_valid;
    logic [OUT_COORD_W-1:0] x_start;
    logic [OUT_COORD_W-1:0] y_start;
    logic [OUT_COORD_W-1:0] x_end;
    logic [OUT_COORD_W-1:0] y_end;
    logic                   frame_done;
  } drc_result_t;

  // Result-side handshake between the scan stage and the output register
  typedef struct packed {
    logic valid;
    logic ready;
  } drc_hs_t;

endpackage

/* rtl/drc_cfg.sv */
// Frame size registers and the derived last column / last row indexes.
// Depends on drc_pkg.
`timescale 1ns / 1ps

module drc_cfg import drc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  drc_cfg_idx_e          cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  output logic [COORD_BITS-1:0] col_last_o,
  output logic [COORD_BITS-1:0] row_last_o
);

  localparam int EXT_W = (COORD_BITS + 1 > CFG_W) ? COORD_BITS + 1 : CFG_W;

  logic [CFG_W-1:0] frame_width_q, frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Zero acts as one, anything above 2^COORD_BITS clamps to it
  function automatic logic [COORD_BITS-1:0] last_index(input logic [CFG_W-1:0] size);
    logic [EXT_W-1:0] size_ext;
    logic [EXT_W-1:0] lim_ext;
    logic [EXT_W-1:0] last_ext;
    size_ext = EXT_W'(size);
    lim_ext  = EXT_W'(1) << COORD_BITS;
    if (size_ext == '0) begin
      last_ext = '0;
    end else if (size_ext > lim_ext) begin
      last_ext = lim_ext - EXT_W'(1);
    end else begin
      last_ext = size_ext - EXT_W'(1);
    end
    return last_ext[COORD_BITS-1:0];
  endfunction

  assign col_last_o = last_index(frame_width_q);
  assign row_last_o = last_index(frame_height_q);

endmodule

/* rtl/drc_scan.sv */
// Input beat register, row span tracking and run merging; builds one result
// per row end that closes a run or ends the frame. Depends on drc_pkg.
`timescale 1ns / 1ps

module drc_scan import drc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIX_W-1:0]      cur_pixel_i,
  input  logic [PIX_W-1:0]      old_pixel_i,
  input  logic [COORD_BITS-1:0] col_last_i,
  input  logic [COORD_BITS-1:0] row_last_i,
  output drc_hs_t               res_hs_o,
  input  logic                  res_ready_i,
  output drc_result_t           res_o
);

  localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

  logic                  in_valid_q;
  logic [PIX_W-1:0]      cur_q, old_q;

  logic                  has_q, has_d;
  logic [COORD_BITS-1:0] first_q, first_d, last_q, last_d;
  logic [COORD_BITS-1:0] col_q, col_d, row_q, row_d;
  logic                  open_q, open_d;
  logic [COORD_BITS-1:0] top_q, top_d, left_q, left_d, right_q, right_d;

  logic                  differ, has_n, row_end, frame_end, produce, advance;
  logic [COORD_BITS-1:0] first_n, last_n, left_m, right_m, top_m;

  always_comb begin
    differ    = (cur_q != old_q);
    has_n     = has_q | differ;
    first_n   = (differ && !has_q) ? col_q : first_q;
    last_n    = differ ? col_q : last_q;
    row_end   = (col_q >= col_last_i);
    frame_end = (row_q >= row_last_i);

    left_m  = (open_q && left_q < first_n) ? left_q : first_n;
    right_m = (open_q && right_q > last_n) ? right_q : last_n;
    top_m   = open_q ? top_q : row_q;

    // a changed row only extends the run unless the frame ends here
    produce = in_valid_q && row_end && (frame_end || (!has_n && open_q));
    advance = in_valid_q && (!produce || res_ready_i);

    has_d   = has_q;
    first_d = first_q;
    last_d  = last_q;
    col_d   = col_q;
    row_d   = row_q;
    open_d  = open_q;
    top_d   = top_q;
    left_d  = left_q;
    right_d = right_q;

    res_o = '0;

    if (!row_end) begin
      has_d   = has_n;
      first_d = first_n;
      last_d  = last_n;
      col_d   = col_q + ONE;
    end else begin
      if (has_n) begin
        open_d  = !frame_end;
        top_d   = top_m;
        left_d  = left_m;
        right_d = right_m;
        res_o.region_valid = 1'b1;
        res_o.x_start      = OUT_COORD_W'(left_m);
        res_o.y_start      = OUT_COORD_W'(top_m);
        res_o.x_end        = OUT_COORD_W'(right_m);
        res_o.y_end        = OUT_COORD_W'(row_q);
        res_o.frame_done   = 1'b1;
      end else if (open_q) begin
        // clean row closes the run one row above
        open_d = 1'b0;
        res_o.region_valid = 1'b1;
        res_o.x_start      = OUT_COORD_W'(left_q);
        res_o.y_start      = OUT_COORD_W'(top_q);
        res_o.x_end        = OUT_COORD_W'(right_q);
        res_o.y_end        = OUT_COORD_W'(row_q - ONE);
        res_o.frame_done   = frame_end;
      end else begin
        res_o.frame_done = 1'b1;
      end
      has_d   = 1'b0;
      first_d = '0;
      last_d  = '0;
      col_d   = '0;
      row_d   = frame_end ? '0 : row_q + ONE;
    end
  end

  assign in_ready_o     = !in_valid_q || advance;
  assign res_hs_o.valid = produce;
  assign res_hs_o.ready = res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cur_q <= cur_pixel_i;
      old_q <= old_pixel_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_q   <= 1'b0;
      first_q <= '0;
      last_q  <= '0;
      col_q   <= '0;
      row_q   <= '0;
      open_q  <= 1'b0;
      top_q   <= '0;
      left_q  <= '0;
      right_q <= '0;
    end else if (advance) begin
      has_q   <= has_d;
      first_q <= first_d;
      last_q  <= last_d;
      col_q   <= col_d;
      row_q   <= row_d;
      open_q  <= open_d;
      top_q   <= top_d;
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

endmodule

/* rtl/drc_out_reg.sv */
// Result register on the master side; holds a beat until it is taken.
// Depends on drc_pkg.
`timescale 1ns / 1ps

module drc_out_reg import drc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        res_valid_i,
  output logic        res_ready_o,
  input  drc_result_t res_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output drc_result_t out_o
);

  logic        valid_q;
  drc_result_t data_q;

  assign res_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

endmodule

/* rtl/dirty_region_coalescer_core.sv */
// Top level of the dirty region coalescer: config registers, scan stage and
// result register. Depends on drc_pkg, drc_cfg, drc_scan and drc_out_reg.
`timescale 1ns / 1ps

// Pixel pairs (current, previously shown) arrive in raster order, one beat per
// clock. From acceptance a beat passes through the input register, where the
// compare and the row/run min-max update run, and then the result register. A
// result beat comes at the end of a row that closes a run of changed rows
// (tuser = 1, coordinates in tdata) and at the last pixel of every frame
// (tlast = 1; tuser = 0 and zero coordinates if no run of changed rows ends
// there). Sustained rate is one pixel per clock; the slave side stalls only
// while a result is held in the output register and another row end needs to
// write it. Frame size registers take effect on the next beat.
module dirty_region_coalescer_core import drc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [0:0]             cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [2*PIX_W-1:0]     s_axis_tdata_i,   // cur_pixel, old_pixel
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [4*OUT_COORD_W-1:0] m_axis_tdata_o, // x_start, y_start, x_end, y_end
  output logic                   m_axis_tuser_o,   // region_valid
  output logic                   m_axis_tlast_o    // frame_done
);

  logic [COORD_BITS-1:0] col_last, row_last;
  drc_hs_t               res_hs;
  logic                  res_ready;
  drc_result_t           res, out;

  drc_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (drc_cfg_idx_e'(cfg_idx_i)),
    .cfg_wdata_i (cfg_wdata_i),
    .col_last_o  (col_last),
    .row_last_o  (row_last)
  );

  drc_scan #(.COORD_BITS(COORD_BITS)) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .cur_pixel_i (s_axis_tdata_i[PIX_W-1:0]),
    .old_pixel_i (s_axis_tdata_i[2*PIX_W-1:PIX_W]),
    .col_last_i  (col_last),
    .row_last_i  (row_last),
    .res_hs_o    (res_hs),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  drc_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_hs.valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (out)
  );

  assign m_axis_tdata_o = {out.y_end, out.x_end, out.y_start, out.x_start};
  assign m_axis_tuser_o = out.region_valid;
  assign m_axis_tlast_o = out.frame_done;

  // A beat without a rectangle only ever marks the end of a frame
  a_empty_is_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tlast_o && m_axis_tdata_o == '0)
    else $error("empty result beat outside frame end");

  // Input stalls only when a result is blocked by a full output register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> res_hs.valid && !res_ready && m_axis_tvalid_o)
    else $error("input stalled without a blocked result");

  // A blocked result stays offered with the same contents
  a_blocked_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_hs.valid && !res_hs.ready |=> res_hs.valid && $stable(res))
    else $error("blocked result changed");

endmodule

/* verif/tb_dirty_region_coalescer_core.sv */
// Self-checking testbench for dirty_region_coalescer_core: streams pixel pairs,
// predicts the rectangle beats in a scoreboard class and checks each result beat.
// Depends on drc_pkg and the RTL of the core.
`timescale 1ns / 1ps

module tb_dirty_region_coalescer_core;
  import drc_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PIXEL_TARGET = 1850;
  localparam int CALM_AFTER   = 1450;  // no idling past this many pixels
  localparam int LONG_HOLD    = 300;

  typedef enum int {ROW_CLEAN, ROW_SPAN, ROW_SPARSE, ROW_NOISE} row_kind_e;

  // Rectangle predictor and store of pending results
  class region_scoreboard;
    logic [CFG_W-1:0]          width_reg;
    logic [CFG_W-1:0]          height_reg;
    logic [COORD_BITS_DEF-1:0] col;
    logic [COORD_BITS_DEF-1:0] row;
    logic [COORD_BITS_DEF-1:0] first_col;
    logic [COORD_BITS_DEF-1:0] last_col;
    logic [COORD_BITS_DEF-1:0] run_top;
    logic [COORD_BITS_DEF-1:0] run_left;
    logic [COORD_BITS_DEF-1:0] run_right;
    bit                        row_dirty;
    bit                        run_open;
    drc_result_t               rect_q[$];
    int                        errors;

    function new();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      col = '0; row = '0; first_col = '0; last_col = '0;
      run_top = '0; run_left = '0; run_right = '0;
      row_dirty = 1'b0;
      run_open  = 1'b0;
      errors    = 0;
    endfunction

    function int eff_size(logic [CFG_W-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > (1 << COORD_BITS_DEF)) return 1 << COORD_BITS_DEF;
      return int'(v);
    endfunction

    function void set_reg(drc_cfg_idx_e idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_FRAME_WIDTH:  width_reg = v;
        CFG_FRAME_HEIGHT: height_reg = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return rect_q.size();
    endfunction

    // Note an accepted pixel beat and queue the rectangle it closes, if any
    function void note_pixel(logic [PIX_W-1:0] cur, logic [PIX_W-1:0] old);
      int          w;
      int          h;
      bit          frame_end;
      bit          emit;
      drc_result_t r;
      w = eff_size(width_reg);
      h = eff_size(height_reg);
      if (cur != old) begin
        if (!row_dirty) first_col = col;
        last_col  = col;
        row_dirty = 1'b1;
      end
      if (int'(col) < w - 1) begin
        col = col + 1'b1;
        return;
      end
      frame_end = int'(row) >= h - 1;
      emit = 1'b0;
      r    = '0;
      if (row_dirty) begin
        if (run_open) begin
          if (first_col < run_left)  run_left  = first_col;
          if (last_col  > run_right) run_right = last_col;
        end else begin
          run_open  = 1'b1;
          run_top   = row;
          run_left  = first_col;
          run_right = last_col;
        end
        if (frame_end) begin
          r.region_valid = 1'b1;
          r.x_start      = run_left;
          r.y_start      = run_top;
          r.x_end        = run_right;
          r.y_end        = row;
          r.frame_done   = 1'b1;
          emit     = 1'b1;
          run_open = 1'b0;
        end
      end else if (run_open) begin
        // clean row closes the run one row above
        r.region_valid = 1'b1;
        r.x_start      = run_left;
        r.y_start      = run_top;
        r.x_end        = run_right;
        r.y_end        = row - 1'b1;
        r.frame_done   = frame_end;
        emit     = 1'b1;
        run_open = 1'b0;
      end else if (frame_end) begin
        r.frame_done = 1'b1;
        emit = 1'b1;
      end
      if (emit) rect_q.push_back(r);
      row_dirty = 1'b0;
      first_col = '0;
      last_col  = '0;
      col       = '0;
      row       = frame_end ? '0 : row + 1'b1;
    endfunction

    function void cmp_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(drc_result_t got);
      drc_result_t want;
      if (rect_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
        return;
      end
      want = rect_q.pop_front();
      cmp_field("region_valid", want.region_valid, got.region_valid);
      cmp_field("x_start", want.x_start, got.x_start);
      cmp_field("y_start", want.y_start, got.y_start);
      cmp_field("x_end", want.x_end, got.x_end);
      cmp_field("y_end", want.y_end, got.y_end);
      cmp_field("frame_done", want.frame_done, got.frame_done);
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n     = 1'b0;
  logic                      cfg_we    = 1'b0;
  drc_cfg_idx_e              cfg_idx   = CFG_FRAME_WIDTH;
  logic [CFG_W-1:0]          cfg_wdata = '0;
  logic                      s_valid   = 1'b0;
  logic                      s_ready;
  logic [2*PIX_W-1:0]        s_data    = '0;
  logic                      m_valid;
  logic                      m_ready   = 1'b0;
  logic [4*OUT_COORD_W-1:0]  m_data;
  logic                      m_user;
  logic                      m_last;

  region_scoreboard sb = new();

  bit        tx_throttle   = 1'b1;
  bit        rx_throttle   = 1'b1;
  bit        long_hold_req = 1'b0;
  int        pixels_sent   = 0;
  int        cycles        = 0;
  int        clean_pct     = 30;
  row_kind_e row_kind      = ROW_CLEAN;
  int        span_lo       = 0;
  int        span_hi       = 0;

  // Directed frame: 3x4 with a clean row splitting two runs, then 1x1 frames
  logic [PIX_W-1:0] dir_cur [0:13] = '{16'hFFFF, 16'h1234, 16'h0000,
                                       16'hFFFF, 16'h0000, 16'hA5A5,
                                       16'h7E7E, 16'h0001, 16'h4321,
                                       16'h0F0F, 16'hF0F0, 16'h8000,
                                       16'h5555, 16'h5555};
  logic [PIX_W-1:0] dir_old [0:13] = '{16'h0000, 16'h1234, 16'hFFFF,
                                       16'hFFFF, 16'h0000, 16'hA5A5,
                                       16'h7E7E, 16'h0000, 16'h4321,
                                       16'h0F0F, 16'hF0F0, 16'h0000,
                                       16'h5555, 16'h5554};

  dirty_region_coalescer_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** dirty_region_coalescer_core: FAILED **");
      $finish;
    end
  end

  // Result side: random stall bursts plus one long hold when requested
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        m_ready <= 1'b0;
      end else if (rx_throttle && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 17) - 1;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : monitor
    drc_result_t got;
    if (rst_n && m_valid && m_ready) begin
      got.region_valid = m_user;
      got.x_start      = m_data[0*OUT_COORD_W +: OUT_COORD_W];
      got.y_start      = m_data[1*OUT_COORD_W +: OUT_COORD_W];
      got.x_end        = m_data[2*OUT_COORD_W +: OUT_COORD_W];
      got.y_end        = m_data[3*OUT_COORD_W +: OUT_COORD_W];
      got.frame_done   = m_last;
      sb.check_result(got);
    end
  end

  task automatic write_reg(drc_cfg_idx_e idx, logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic push_pixel(logic [PIX_W-1:0] cur, logic [PIX_W-1:0] old);
    int gap;
    if (tx_throttle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {old, cur};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    sb.note_pixel(cur, old);
    pixels_sent++;
  endtask

  // Drop valid, wait for every pending rectangle, then let the pipeline settle
  task automatic settle();
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic plan_row(int w);
    if ($urandom_range(0, 99) < clean_pct) begin
      row_kind = ROW_CLEAN;
    end else begin
      case ($urandom_range(0, 3))
        0, 1: row_kind = ROW_SPAN;
        2: row_kind = ROW_SPARSE;
        default: row_kind = ROW_NOISE;
      endcase
    end
    span_lo = $urandom_range(0, w - 1);
    span_hi = $urandom_range(span_lo, w - 1);
  endtask

  function automatic bit pick_dirty(int c);
    case (row_kind)
      ROW_CLEAN:  return 1'b0;
      ROW_SPAN: begin
        if (c == span_lo || c == span_hi) return 1'b1;
        if (c > span_lo && c < span_hi) return 1'($urandom_range(0, 1));
        return 1'b0;
      end
      ROW_SPARSE: return $urandom_range(0, 7) == 0;
      default:    return 1'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic send_random(int count);
    int               w;
    logic [PIX_W-1:0] cur;
    logic [PIX_W-1:0] flip;
    w = sb.eff_size(sb.width_reg);
    for (int i = 0; i < count; i++) begin
      if (i == 0 || sb.col == 0) plan_row(w);
      cur = 16'($urandom);
      if (pick_dirty(int'(sb.col))) begin
        // a single flipped bit must still count as a change
        if ($urandom_range(0, 3) == 0) flip = 16'h0001 << $urandom_range(0, 15);
        else flip = 16'($urandom);
        if (flip == '0) flip = 16'h8000;
        push_pixel(cur, cur ^ flip);
      end else begin
        push_pixel(cur, cur);
      end
    end
  endtask

  initial begin : stimulus
    int               phase;
    int               frames;
    int               count;
    int               pick;
    int               fsize;
    logic [CFG_W-1:0] wv;
    logic [CFG_W-1:0] hv;
    bit               both;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(CFG_FRAME_WIDTH, 9'd3);
    write_reg(CFG_FRAME_HEIGHT, 9'd4);
    for (int i = 0; i < 12; i++) push_pixel(dir_cur[i], dir_old[i]);
    settle();
    // zero sizes act as a 1x1 frame
    write_reg(CFG_FRAME_WIDTH, 9'd0);
    write_reg(CFG_FRAME_HEIGHT, 9'd0);
    for (int i = 12; i < 14; i++) push_pixel(dir_cur[i], dir_old[i]);
    settle();

    phase = 0;
    while (pixels_sent < PIXEL_TARGET) begin
      frames = $urandom_range(1, 4);
      both   = 1'b0;
      case (phase)
        0: begin wv = 9'd511; hv = 9'd1;   frames = 1; both = 1'b1; end
        1: begin wv = 9'd1;   hv = 9'd256; frames = 1; both = 1'b1; end
        2: begin wv = 9'd3;   hv = 9'd5;   frames = 4; both = 1'b1; end
        default: begin
          pick = $urandom_range(0, 99);
          if (pick < 85) begin
            wv = 9'($urandom_range(1, 16));
            hv = 9'($urandom_range(1, 8));
          end else if (pick < 94) begin
            wv = 9'($urandom_range(0, 3));
            hv = 9'($urandom_range(0, 3));
          end else begin
            wv = 9'($urandom_range(200, 511));
            hv = 9'd1;
            frames = 1;
          end
        end
      endcase
      if (both || $urandom_range(0, 3) != 0) write_reg(CFG_FRAME_WIDTH, wv);
      if (both || $urandom_range(0, 3) != 0) write_reg(CFG_FRAME_HEIGHT, hv);

      fsize = sb.eff_size(sb.width_reg) * sb.eff_size(sb.height_reg);
      if (fsize > 300) frames = 1;
      count = frames * fsize;
      // leave some phases mid-frame so the next size change lands inside a frame
      if (fsize > 1 && $urandom_range(0, 4) == 0) count += $urandom_range(1, fsize - 1);
      if (count > PIXEL_TARGET - pixels_sent) count = PIXEL_TARGET - pixels_sent;

      clean_pct = $urandom_range(0, 60);
      if (pixels_sent >= CALM_AFTER) begin
        tx_throttle = 1'b0;
        rx_throttle = 1'b0;
      end else begin
        tx_throttle = $urandom_range(0, 3) != 0;
        rx_throttle = $urandom_range(0, 3) != 0;
      end
      if ((phase == 2 || phase == 7) && pixels_sent < CALM_AFTER) long_hold_req = 1'b1;

      send_random(count);
      settle();
      phase++;
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** dirty_region_coalescer_core: PASSED **");
    end else begin
      $display("** dirty_region_coalescer_core: FAILED **");
    end
    $finish;
  end

endmodule
